FILE: hdl/sfpd_pkg.sv
// sfpd_pkg: shared widths, codes and types of the start-of-frame deframer
// no dependencies; imported by every other file of the block but sfpd_checker
`default_nettype none

package sfpd_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 16;
	localparam int PAY_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int POS_W      = 2;
	localparam int LANE_W     = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// register reset values
	localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'h41;
	localparam logic [BYTE_W-1:0] RST_TOGGLE_A   = 8'h31;
	localparam logic [BYTE_W-1:0] RST_TOGGLE_B   = 8'hD2;

	// last byte position of the data word
	localparam logic [POS_W-1:0] POS_LAST = 2'd3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_TOGGLE_A   = 2'd1,
		REG_TOGGLE_B   = 2'd2
	} reg_idx_t;

	// frame field being received
	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_CMD  = 4'b0010,
		PH_CFG  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	// classified byte operation handed from front to back
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_MISS  = 3'd1,
		OP_CMD   = 3'd2,
		OP_CFG   = 3'd3,
		OP_DATA  = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [LANE_W-1:0]   lane;
		logic                last;
		logic [BYTE_W-1:0]   data;
	} op_t;

	// command codes used by the dispatch stage
	typedef struct packed {
		logic [BYTE_W-1:0] code_a;
		logic [BYTE_W-1:0] code_b;
	} toggle_codes_t;

endpackage

`default_nettype wire

FILE: hdl/sfpd_if.sv
// sfpd_if: valid/ready channel interfaces of the deframer
// depends on sfpd_pkg for field widths
`default_nettype none

// received byte channel
interface sfpd_byte_if import sfpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// per-byte result channel
interface sfpd_res_if import sfpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              frame_done;
	logic [BYTE_W-1:0] frame_cmd;
	logic [CFG_W-1:0]  frame_cfg;
	logic [PAY_W-1:0]  frame_payload;
	logic              pin_a_level;
	logic              pin_b_level;
	logic              start_miss;

	modport source (output valid, output frame_done, output frame_cmd, output frame_cfg,
		output frame_payload, output pin_a_level, output pin_b_level, output start_miss,
		input ready);
	modport sink (input valid, input frame_done, input frame_cmd, input frame_cfg,
		input frame_payload, input pin_a_level, input pin_b_level, input start_miss,
		output ready);
endinterface

// register write channel
interface sfpd_cfg_if import sfpd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/sfpd_front.sv
// sfpd_front: frame tracker that classifies each received byte into an operation
// depends on sfpd_pkg and sfpd_byte_if
`default_nettype none

module sfpd_front import sfpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfpd_byte_if.sink        rx,
	input  wire logic [BYTE_W-1:0] start_byte,
	output op_t              op,
	output logic             op_valid,
	input  wire logic        op_ready
);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             accept;

	// a beat is taken whenever the queue has room
	assign rx.ready = op_ready;
	assign accept   = rx.valid && op_ready;
	assign op_valid = rx.valid;

	// classify the byte and advance the frame position
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		op.kind   = OP_MISS;
		op.lane   = '0;
		op.last   = 1'b0;
		op.data   = rx.rx_byte;
		unique case (phase_q)
			PH_HUNT: begin
				pos_d = '0;
				if (rx.rx_byte == start_byte) begin
					op.kind = OP_START;
					phase_d = PH_CMD;
				end else begin
					op.kind = OP_MISS;
				end
			end
			PH_CMD: begin
				op.kind = OP_CMD;
				pos_d   = '0;
				phase_d = PH_CFG;
			end
			PH_CFG: begin
				op.kind = OP_CFG;
				op.lane = {1'b0, pos_q[0]};
				if (pos_q[0]) begin
					pos_d   = '0;
					phase_d = PH_DATA;
				end else begin
					pos_d = {{(POS_W-1){1'b0}}, 1'b1};
				end
			end
			PH_DATA: begin
				op.kind = OP_DATA;
				op.lane = pos_q;
				if (pos_q == POS_LAST) begin
					op.last = 1'b1;
					pos_d   = '0;
					phase_d = PH_HUNT;
				end else begin
					pos_d = pos_q + {{(POS_W-1){1'b0}}, 1'b1};
				end
			end
			default: begin
				pos_d   = '0;
				phase_d = PH_HUNT;
			end
		endcase
	end

	// frame position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sfpd_fifo.sv
// sfpd_fifo: short operation queue between the classifier and the executor
// depends on sfpd_pkg for op_t and the queue depth
`default_nettype none

module sfpd_fifo import sfpd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire op_t  wr_op,
	input  wire logic wr_valid,
	output logic      wr_ready,
	output op_t       rd_op,
	output logic      rd_valid,
	input  wire logic rd_ready
);

	op_t                   entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  push, pop;

	assign wr_ready = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + {{(FIFO_PTR_W-1){1'b0}}, 1'b1};
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + {{(FIFO_PTR_W-1){1'b0}}, 1'b1};
			end
			priority if (push && !pop) begin
				count_q <= count_q + {{FIFO_PTR_W{1'b0}}, 1'b1};
			end else if (pop && !push) begin
				count_q <= count_q - {{FIFO_PTR_W{1'b0}}, 1'b1};
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sfpd_back.sv
// sfpd_back: executor that assembles frame words, toggles pins and holds the result beat
// depends on sfpd_pkg and sfpd_res_if
`default_nettype none

module sfpd_back import sfpd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire op_t     op,
	input  wire logic    op_valid,
	output logic         op_ready,
	input  wire toggle_codes_t codes,
	sfpd_res_if.source   res
);

	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [CFG_W-1:0]  cfg_q, cfg_d;
	logic [PAY_W-1:0]  pay_q, pay_d;
	logic              pin_a_q, pin_a_d;
	logic              pin_b_q, pin_b_d;
	logic              done_q, done_d;
	logic              miss_q, miss_d;
	logic              res_valid_q;
	logic              pop;

	// take an operation when the result register is free or being drained
	assign op_ready = !res_valid_q || res.ready;
	assign pop      = op_valid && op_ready;

	// apply the operation to the frame state
	always_comb begin
		cmd_d   = cmd_q;
		cfg_d   = cfg_q;
		pay_d   = pay_q;
		pin_a_d = pin_a_q;
		pin_b_d = pin_b_q;
		done_d  = 1'b0;
		miss_d  = 1'b0;
		unique case (op.kind)
			OP_START: begin
			end
			OP_MISS: begin
				miss_d = 1'b1;
			end
			OP_CMD: begin
				cmd_d = op.data;
			end
			OP_CFG: begin
				cfg_d[{op.lane[0], 3'b000} +: BYTE_W] = op.data;
			end
			OP_DATA: begin
				pay_d[{op.lane, 3'b000} +: BYTE_W] = op.data;
				if (op.last) begin
					done_d = 1'b1;
					// code a wins when both codes are equal
					priority if (cmd_q == codes.code_a) begin
						pin_a_d = !pin_a_q;
					end else if (cmd_q == codes.code_b) begin
						pin_b_d = !pin_b_q;
					end else begin
						pin_a_d = pin_a_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// frame state, which is also the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			cfg_q   <= '0;
			pay_q   <= '0;
			pin_a_q <= 1'b0;
			pin_b_q <= 1'b0;
			done_q  <= 1'b0;
			miss_q  <= 1'b0;
		end else if (pop) begin
			cmd_q   <= cmd_d;
			cfg_q   <= cfg_d;
			pay_q   <= pay_d;
			pin_a_q <= pin_a_d;
			pin_b_q <= pin_b_d;
			done_q  <= done_d;
			miss_q  <= miss_d;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (op_ready) begin
			res_valid_q <= op_valid;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.frame_done    = done_q;
	assign res.frame_cmd     = cmd_q;
	assign res.frame_cfg     = cfg_q;
	assign res.frame_payload = pay_q;
	assign res.pin_a_level   = pin_a_q;
	assign res.pin_b_level   = pin_b_q;
	assign res.start_miss    = miss_q;

endmodule

`default_nettype wire

FILE: hdl/sof_frame_parser_dispatch_unit.sv
// Start-of-frame byte deframer with command dispatch. Each received byte beat
// yields exactly one result beat: frame_done marks the last data byte of a
// frame, start_miss marks a non-start byte seen while hunting, and the
// command, config word, data word and pin levels show the frame state after
// that byte. One byte per clock is sustained while result beats are taken;
// a byte is classified and written into the queue at the edge that takes it
// and from there loads the result register when the executor is free. A
// four-entry operation queue decouples the classifier from the executor, so
// input keeps flowing while a result waits to be taken, until the queue fills.
// Register writes are accepted every cycle; made while no byte is in flight
// they take effect on the next byte.
// top level: register file, classifier, queue and executor
// depends on sfpd_pkg, sfpd_if, sfpd_front, sfpd_fifo, sfpd_back
`default_nettype none

module sof_frame_parser_dispatch_unit import sfpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfpd_byte_if.sink  rx,
	sfpd_res_if.source res,
	sfpd_cfg_if.sink   cfg
);

	logic [BYTE_W-1:0] start_byte_q;
	toggle_codes_t     codes_q;
	op_t               front_op, back_op;
	logic              front_valid, front_ready;
	logic              back_valid, back_ready;

	// register writes always complete
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= RST_START_BYTE;
			codes_q.code_a <= RST_TOGGLE_A;
			codes_q.code_b <= RST_TOGGLE_B;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_START_BYTE: start_byte_q   <= cfg.wdata;
				REG_TOGGLE_A:   codes_q.code_a <= cfg.wdata;
				REG_TOGGLE_B:   codes_q.code_b <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	sfpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.start_byte (start_byte_q),
		.op         (front_op),
		.op_valid   (front_valid),
		.op_ready   (front_ready)
	);

	sfpd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_op    (front_op),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_op    (back_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	sfpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.codes    (codes_q),
		.res      (res)
	);

endmodule

`default_nettype wire

FILE: hdl/sfpd_checker.sv
// sfpd_checker: port-level checks of the deframer, bound to the top level
// depends on the top level's port names only
`default_nettype none

module sfpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic frame_done,
	input wire logic start_miss,
	input wire logic pin_a_level,
	input wire logic pin_b_level,
	input wire logic [31:0] frame_payload
);

	logic res_fire;
	logic pin_a_q, pin_b_q;

	assign res_fire = res_valid && res_ready;

	// pin levels as of the last result beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_a_q <= 1'b0;
			pin_b_q <= 1'b0;
		end else if (res_fire) begin
			pin_a_q <= pin_a_level;
			pin_b_q <= pin_b_level;
		end
	end

	// a byte cannot both finish a frame and miss the start
	a_done_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(frame_done && start_miss))
		else $error("frame_done and start_miss both set");

	// pins change only on a beat that completes a frame
	a_pins_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && !frame_done) |-> (pin_a_level == pin_a_q && pin_b_level == pin_b_q))
		else $error("pin level changed without a completed frame");

	// at most one pin toggles per frame
	a_one_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && frame_done) |-> !(pin_a_level != pin_a_q && pin_b_level != pin_b_q))
		else $error("both pins toggled on one frame");

	// a stalled result beat holds its valid, payload and frame_done
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(frame_payload)
			&& $stable(frame_done)))
		else $error("result beat changed while stalled");

endmodule

bind sof_frame_parser_dispatch_unit sfpd_checker u_sfpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.frame_done    (res.frame_done),
	.start_miss    (res.start_miss),
	.pin_a_level   (res.pin_a_level),
	.pin_b_level   (res.pin_b_level),
	.frame_payload (res.frame_payload)
);

`default_nettype wire
